/* rtl/assert_macros.svh */
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold on every clock edge outside reset
`define LSAG_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("lsag assertion failed");

// consequent must hold in the cycle after the antecedent
`define LSAG_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("lsag assertion failed");

`endif

/* rtl/lsag_pkg.sv */
package lsag_pkg;

	localparam int PIXEL_COUNT = 16;
	localparam int PIX_W       = 6;
	localparam logic [PIX_W-1:0] PIX_LAST = PIX_W'(PIXEL_COUNT - 1);

	localparam logic [3:0] MODE_IDLE   = 4'd0;
	localparam logic [3:0] MODE_CHASE  = 4'd1;
	localparam logic [3:0] MODE_RED    = 4'd2;
	localparam logic [3:0] MODE_GREEN  = 4'd3;
	localparam logic [3:0] MODE_BLUE   = 4'd4;
	localparam logic [3:0] MODE_SCAN   = 4'd5;
	localparam logic [3:0] MODE_WHITE  = 4'd6;
	localparam logic [3:0] MODE_TEST   = 4'd7;
	localparam logic [3:0] MODE_BREATH = 4'd8;

	localparam logic [31:0] CHASE_MS       = 32'd100;
	localparam logic [31:0] SCAN_MS        = 32'd150;
	localparam logic [31:0] TEST_STEP_MS   = 32'd800;
	localparam logic [31:0] BREATH_RUN_MS  = 32'd10000;
	localparam logic [31:0] BREATH_TICK_MS = 32'd20;

	// floor(x/20) for x below 10000 as (x * 3277) >> 16
	localparam int ELAPSED_W   = 14;
	localparam logic [11:0] BREATH_RECIP = 12'd3277;
	localparam int RECIP_SHIFT = 16;

	localparam logic [2:0] TEST_DONE = 3'd7;

	localparam logic [7:0] SCAN_PEAK = 8'd255;
	localparam logic [7:0] SCAN_SIDE = 8'd100;
	localparam logic [7:0] SCAN_BASE = 8'd20;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic calc;
		logic update;
		logic setup;
		logic load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic frame;
		logic slot_free;
		logic last;
	} status_t;

	function automatic logic [7:0] hue_offset(input logic [PIX_W-1:0] idx);
		return 8'((int'(idx) * 256) / PIXEL_COUNT);
	endfunction

	function automatic rgb_t wheel(input logic [7:0] hue);
		logic [7:0] p;
		logic [7:0] q;
		rgb_t c;
		p = 8'd255 - hue;
		if (p < 8'd85) begin
			q = p;
			c.red   = 8'd255 - 8'(q * 8'd3);
			c.green = 8'd0;
			c.blue  = 8'(q * 8'd3);
		end else if (p < 8'd170) begin
			q = p - 8'd85;
			c.red   = 8'd0;
			c.green = 8'(q * 8'd3);
			c.blue  = 8'd255 - 8'(q * 8'd3);
		end else begin
			q = p - 8'd170;
			c.red   = 8'(q * 8'd3);
			c.green = 8'd255 - 8'(q * 8'd3);
			c.blue  = 8'd0;
		end
		return c;
	endfunction

	function automatic rgb_t test_color(input logic [2:0] idx);
		rgb_t c;
		case (idx)
			3'd0:    c = '{8'd255, 8'd0,   8'd0};
			3'd1:    c = '{8'd0,   8'd255, 8'd0};
			3'd2:    c = '{8'd0,   8'd0,   8'd255};
			3'd3:    c = '{8'd255, 8'd255, 8'd0};
			3'd4:    c = '{8'd255, 8'd0,   8'd255};
			3'd5:    c = '{8'd0,   8'd255, 8'd255};
			3'd6:    c = '{8'd255, 8'd255, 8'd255};
			default: c = '{8'd0,   8'd0,   8'd0};
		endcase
		return c;
	endfunction

endpackage

/* rtl/lsag_tick_if.sv */
interface lsag_tick_if;
	logic        valid;
	logic        ready;
	logic [31:0] now_ms;
	logic        load_mode;
	logic [3:0]  mode;

	modport source (output valid, now_ms, load_mode, mode, input ready);
	modport sink   (input valid, now_ms, load_mode, mode, output ready);
endinterface

/* rtl/lsag_pix_if.sv */
interface lsag_pix_if;
	logic       valid;
	logic       ready;
	logic [5:0] pixel_index;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic       last_pixel;

	modport source (output valid, pixel_index, red, green, blue, last_pixel, input ready);
	modport sink   (input valid, pixel_index, red, green, blue, last_pixel, output ready);
endinterface

/* rtl/lsag_cfg_if.sv */
interface lsag_cfg_if;
	logic valid;
	logic ready;
	logic led_enable;

	modport source (output valid, led_enable, input ready);
	modport sink   (input valid, led_enable, output ready);
endinterface

/* rtl/lsag_ctrl.sv */
`include "assert_macros.svh"

module lsag_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             tick_valid,
	output logic             tick_ready,
	output lsag_pkg::cmd_t   cmd,
	input  lsag_pkg::status_t st
);
	import lsag_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CALC,
		S_UPDATE,
		S_SETUP,
		S_EMIT
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (tick_valid) state_q <= S_CALC;
				end
				S_CALC: begin
					state_q <= S_UPDATE;
				end
				S_UPDATE: begin
					state_q <= st.frame ? S_SETUP : S_IDLE;
				end
				S_SETUP: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (st.slot_free && st.last) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign tick_ready = (state_q == S_IDLE);

	always_comb begin
		cmd.accept = tick_valid && (state_q == S_IDLE);
		cmd.calc   = (state_q == S_CALC);
		cmd.update = (state_q == S_UPDATE);
		cmd.setup  = (state_q == S_SETUP);
		cmd.load   = (state_q == S_EMIT) && st.slot_free;
	end

	// a tick that yields no frame goes straight back to taking ticks
	`LSAG_ASSERT_NEXT(a_noframe_idle, clk, arst_n, cmd.update && !st.frame, state_q == S_IDLE)
	// the final pixel load ends the frame
	`LSAG_ASSERT_NEXT(a_last_idle, clk, arst_n, cmd.load && st.last, state_q == S_IDLE)

endmodule

/* rtl/lsag_dp.sv */
`include "assert_macros.svh"

module lsag_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  lsag_pkg::cmd_t               cmd,
	output lsag_pkg::status_t            st,
	input  logic [31:0]                  now_ms,
	input  logic                         load_mode,
	input  logic [3:0]                   mode,
	input  logic                         cfg_valid,
	input  logic                         cfg_led_enable,
	input  logic                         out_ready,
	output logic                         out_valid,
	output logic [lsag_pkg::PIX_W-1:0]   out_pixel_index,
	output logic [7:0]                   out_red,
	output logic [7:0]                   out_green,
	output logic [7:0]                   out_blue,
	output logic                         out_last_pixel
);
	import lsag_pkg::*;

	typedef enum logic [1:0] {
		SEL_FLAT,
		SEL_BREATH,
		SEL_CHASE,
		SEL_SCAN
	} sel_t;

	// animation state
	logic              led_en_q;
	logic [3:0]        cur_mode_q;
	logic [31:0]       lft_q;
	logic [7:0]        step_q;
	logic [PIX_W-1:0]  scan_pos_q;
	logic [31:0]       tst_q;
	logic [2:0]        tidx_q;
	logic [31:0]       bst_q;
	logic [31:0]       blt_q;

	// tick evaluation
	logic [31:0]          now_s1;
	logic                 gt100_q, gt150_q, ge800_q, ge10000_q, ge20_q;
	logic [31:0]          tst_eff_q, bst_eff_q, blt_eff_q;
	logic [2:0]           tidx_eff_q;
	logic [ELAPSED_W-1:0] el_q;

	// frame
	sel_t             sel_q;
	rgb_t             rgb_q;
	logic [7:0]       phase_q;
	logic [PIX_W-1:0] nxt_q, prv_q;
	logic [PIX_W-1:0] cnt_q;
	logic             out_valid_q;
	logic [PIX_W-1:0] out_idx_q;
	rgb_t             out_rgb_q;
	logic             out_last_q;

	logic [31:0] tst_eff_c, bst_eff_c, blt_eff_c, el_c;
	logic [31:0] tst_next_c;
	logic [2:0]  tidx_next_c;
	logic [ELAPSED_W+11:0] prod_c;
	logic        frame_c;
	logic [7:0]  level_c;
	rgb_t        pix_c;
	sel_t        sel_c;
	rgb_t        rgb_c;

	always_comb begin
		tst_eff_c = (tst_q == '0) ? now_s1 : tst_q;
		bst_eff_c = (bst_q == '0) ? now_s1 : bst_q;
		blt_eff_c = (bst_q == '0) ? now_s1 : blt_q;
		el_c      = now_s1 - bst_eff_c;
	end

	always_comb begin
		tst_next_c  = tst_eff_q + (ge800_q ? TEST_STEP_MS : 32'd0);
		tidx_next_c = tidx_eff_q + 3'(ge800_q);
		prod_c      = el_q * BREATH_RECIP;
	end

	always_comb begin
		case (cur_mode_q)
			MODE_CHASE:  frame_c = gt100_q;
			MODE_SCAN:   frame_c = gt150_q;
			MODE_RED,
			MODE_GREEN,
			MODE_BLUE,
			MODE_WHITE,
			MODE_TEST:   frame_c = 1'b1;
			MODE_BREATH: frame_c = ge10000_q || ge20_q;
			default:     frame_c = 1'b0;
		endcase
	end

	// frame source picked at update
	always_comb begin
		sel_c = SEL_FLAT;
		rgb_c = '0;
		case (cur_mode_q)
			MODE_CHASE:  sel_c = SEL_CHASE;
			MODE_SCAN:   sel_c = SEL_SCAN;
			MODE_RED:    rgb_c = '{8'd255, 8'd0, 8'd0};
			MODE_GREEN:  rgb_c = '{8'd0, 8'd255, 8'd0};
			MODE_BLUE:   rgb_c = '{8'd0, 8'd0, 8'd255};
			MODE_WHITE:  rgb_c = '{8'd255, 8'd255, 8'd255};
			MODE_TEST:   rgb_c = test_color(tidx_next_c);
			MODE_BREATH: begin
				if (!ge10000_q) sel_c = SEL_BREATH;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		st.frame     = led_en_q && frame_c;
		st.slot_free = !out_valid_q || out_ready;
		st.last      = (cnt_q == PIX_LAST);
	end

	// triangle: up by two for the first half, down by two after
	assign level_c = phase_q[7] ? (8'd255 - {phase_q[6:0], 1'b0}) : {phase_q[6:0], 1'b0};

	always_comb begin
		case (sel_q)
			SEL_CHASE: pix_c = wheel(hue_offset(cnt_q) + step_q);
			SEL_SCAN: begin
				pix_c.red   = 8'd0;
				pix_c.green = 8'd0;
				if (cnt_q == scan_pos_q)
					pix_c.blue = SCAN_PEAK;
				else if (cnt_q == nxt_q || cnt_q == prv_q)
					pix_c.blue = SCAN_SIDE;
				else
					pix_c.blue = SCAN_BASE;
			end
			default:   pix_c = rgb_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_en_q    <= 1'b0;
			cur_mode_q  <= MODE_IDLE;
			lft_q       <= '0;
			step_q      <= '0;
			scan_pos_q  <= '0;
			tst_q       <= '0;
			tidx_q      <= '0;
			bst_q       <= '0;
			blt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) led_en_q <= cfg_led_enable;
			if (cmd.accept && load_mode) cur_mode_q <= mode;
			if (cmd.update && led_en_q) begin
				case (cur_mode_q)
					MODE_CHASE: begin
						if (gt100_q) begin
							lft_q  <= now_s1;
							step_q <= step_q + 8'd1;
						end
					end
					MODE_SCAN: begin
						if (gt150_q) begin
							lft_q      <= now_s1;
							scan_pos_q <= (scan_pos_q == PIX_LAST) ? '0 : scan_pos_q + 1'b1;
						end
					end
					MODE_TEST: begin
						tidx_q <= tidx_next_c;
						if (tidx_next_c == TEST_DONE) begin
							cur_mode_q <= MODE_IDLE;
							tst_q      <= '0;
						end else begin
							tst_q <= tst_next_c;
						end
					end
					MODE_BREATH: begin
						if (ge10000_q) begin
							cur_mode_q <= MODE_IDLE;
							bst_q      <= '0;
						end else begin
							bst_q <= bst_eff_q;
							blt_q <= ge20_q ? now_s1 : blt_eff_q;
						end
					end
					default: begin
					end
				endcase
			end
			if (cmd.load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) now_s1 <= now_ms;
		if (cmd.calc) begin
			gt100_q    <= (now_s1 - lft_q) > CHASE_MS;
			gt150_q    <= (now_s1 - lft_q) > SCAN_MS;
			tst_eff_q  <= tst_eff_c;
			tidx_eff_q <= (tst_q == '0) ? 3'd0 : tidx_q;
			ge800_q    <= (now_s1 - tst_eff_c) >= TEST_STEP_MS;
			bst_eff_q  <= bst_eff_c;
			blt_eff_q  <= blt_eff_c;
			ge10000_q  <= el_c >= BREATH_RUN_MS;
			ge20_q     <= (now_s1 - blt_eff_c) >= BREATH_TICK_MS;
			el_q       <= el_c[ELAPSED_W-1:0];
		end
		if (cmd.update) begin
			phase_q <= prod_c[RECIP_SHIFT+7:RECIP_SHIFT];
			sel_q   <= sel_c;
			rgb_q   <= rgb_c;
		end
		if (cmd.setup) begin
			cnt_q <= '0;
			nxt_q <= (scan_pos_q == PIX_LAST) ? '0 : scan_pos_q + 1'b1;
			prv_q <= (scan_pos_q == '0) ? PIX_LAST : scan_pos_q - 1'b1;
			if (sel_q == SEL_BREATH) rgb_q <= '{8'd0, level_c, 8'd0};
		end
		if (cmd.load) begin
			cnt_q      <= cnt_q + 1'b1;
			out_idx_q  <= cnt_q;
			out_rgb_q  <= pix_c;
			out_last_q <= (cnt_q == PIX_LAST);
		end
	end

	assign out_valid       = out_valid_q;
	assign out_pixel_index = out_idx_q;
	assign out_red         = out_rgb_q.red;
	assign out_green       = out_rgb_q.green;
	assign out_blue        = out_rgb_q.blue;
	assign out_last_pixel  = out_last_q;

	`LSAG_ASSERT(a_scan_range, clk, arst_n, scan_pos_q <= PIX_LAST)
	`LSAG_ASSERT(a_test_done_clear, clk, arst_n, tidx_q == TEST_DONE |-> tst_q == '0)
	`LSAG_ASSERT(a_load_range, clk, arst_n, cmd.load |-> cnt_q <= PIX_LAST)

endmodule

/* rtl/led_strip_animation_generator.sv */
// tick to first pixel: evaluate, update, frame setup, then the first pixel load
// a frame is PIXEL_COUNT pixels, one per cycle while the sink keeps ready high
// a tick that makes a frame goes on to setup and emit; one without a frame ends at update
// the next tick is taken while the final pixel of a frame still waits in the output register
// arst_n clears mode, timers, chase step, scan position and led_enable; no frame after reset

`include "assert_macros.svh"

module led_strip_animation_generator (
	input  logic          clk,
	input  logic          arst_n,
	lsag_tick_if.sink     tick,
	lsag_pix_if.source    pixel,
	lsag_cfg_if.sink      cfg
);
	import lsag_pkg::*;

	cmd_t    cmd;
	status_t st;
	logic    tick_ready;

	// sequencer: one tick at a time through evaluate and update, then setup and emit for a frame
	lsag_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick_valid (tick.valid),
		.tick_ready (tick_ready),
		.cmd        (cmd),
		.st         (st)
	);

	// animation state, timers and the pixel output register
	lsag_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.st              (st),
		.now_ms          (tick.now_ms),
		.load_mode       (tick.load_mode),
		.mode            (tick.mode),
		.cfg_valid       (cfg.valid),
		.cfg_led_enable  (cfg.led_enable),
		.out_ready       (pixel.ready),
		.out_valid       (pixel.valid),
		.out_pixel_index (pixel.pixel_index),
		.out_red         (pixel.red),
		.out_green       (pixel.green),
		.out_blue        (pixel.blue),
		.out_last_pixel  (pixel.last_pixel)
	);

	// input side only takes a tick when the sequencer is free
	assign tick.ready = tick_ready;

	// register writes go straight into the enable register, so the port never stalls
	assign cfg.ready = 1'b1;

	// the controller only loads a pixel into a free output slot
	`LSAG_ASSERT(a_no_overwrite, clk, arst_n, pixel.valid && !pixel.ready |-> !cmd.load)

endmodule

/* tb/led_strip_animation_generator_tb.sv */
`timescale 1ns / 1ps

// self-checking bench for the led strip animation generator
module led_strip_animation_generator_tb;
	import lsag_pkg::*;

	localparam int CLK_HALF      = 5;
	localparam int RESET_CYCLES  = 4;
	// margin for ticks still in flight after the queues drain
	localparam int SETTLE_CYCLES = 2 * PIXEL_COUNT + 8;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int REPORT_MAX    = 10;

	// one tick transaction as the sender queues it
	typedef struct packed {
		logic [31:0] now_ms;
		logic        load_mode;
		logic [3:0]  mode;
	} tick_t;

	// one pixel transaction as the strip receives it
	typedef struct packed {
		logic [5:0] pixel_index;
		rgb_t       color;
		logic       last_pixel;
	} pixel_t;

	logic clk = 1'b0;
	logic arst_n;

	lsag_tick_if tick_bus();
	lsag_pix_if  pixel_bus();
	lsag_cfg_if  cfg_bus();

	led_strip_animation_generator u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.tick  (tick_bus),
		.pixel (pixel_bus),
		.cfg   (cfg_bus)
	);

	always #CLK_HALF clk = ~clk;

	// ticks still to send, pixels still owed by the block, enable values to write
	tick_t  ticks_pending[$];
	pixel_t pixels_due[$];
	logic   enable_writes[$];

	int          send_gap_pct;
	int          recv_stall_pct;
	int          enable_writes_done;
	int          ticks_queued;
	int          ticks_taken;
	int          bad_pixels;
	int          cycles_run;
	logic [31:0] sim_ms;

	tick_t  next_tick;
	tick_t  bus_tick;
	pixel_t want_px;
	pixel_t got_px;

	// animation state as the block should hold it
	logic        strip_on;
	logic [3:0]  shown_mode;
	logic [31:0] frame_stamp;
	logic [7:0]  chase_pos;
	logic [5:0]  scan_pos;
	logic [31:0] test_stamp;
	logic [2:0]  test_idx;
	logic [31:0] breath_origin;
	logic [31:0] breath_stamp;

	// color wheel: three linear ramps over the inverted hue
	function automatic rgb_t hue_to_rgb(input logic [7:0] hue);
		int seg;
		rgb_t c;
		seg = 255 - int'(hue);
		if (seg < 85) begin
			c.red   = 8'(255 - 3 * seg);
			c.green = 8'd0;
			c.blue  = 8'(3 * seg);
		end else if (seg < 170) begin
			seg     = seg - 85;
			c.red   = 8'd0;
			c.green = 8'(3 * seg);
			c.blue  = 8'(255 - 3 * seg);
		end else begin
			seg     = seg - 170;
			c.red   = 8'(3 * seg);
			c.green = 8'(255 - 3 * seg);
			c.blue  = 8'd0;
		end
		return c;
	endfunction

	// test card: red, green, blue, yellow, magenta, cyan, white
	function automatic rgb_t test_card(input logic [2:0] idx);
		rgb_t c;
		c.red   = (idx == 3'd0 || idx == 3'd3 || idx == 3'd4 || idx == 3'd6) ? 8'd255 : 8'd0;
		c.green = (idx == 3'd1 || idx == 3'd3 || idx == 3'd5 || idx == 3'd6) ? 8'd255 : 8'd0;
		c.blue  = (idx == 3'd2 || idx == 3'd4 || idx == 3'd5 || idx == 3'd6) ? 8'd255 : 8'd0;
		return c;
	endfunction

	function automatic void push_pixel(input int idx, input rgb_t c);
		pixel_t p;
		p.pixel_index = 6'(idx);
		p.color       = c;
		p.last_pixel  = (idx == PIXEL_COUNT - 1);
		pixels_due.push_back(p);
	endfunction

	function automatic void push_solid(input rgb_t c);
		int i;
		for (i = 0; i < PIXEL_COUNT; i++)
			push_pixel(i, c);
	endfunction

	// works out the frame, if any, that one accepted tick causes
	function automatic void render_tick(input tick_t t);
		logic [31:0] since;
		int i;
		int phase;
		int level;
		int nxt;
		int prv;
		// a mode load lands even while the strip is off
		if (t.load_mode)
			shown_mode = t.mode;
		if (!strip_on)
			return;
		case (shown_mode)
			MODE_CHASE: begin
				if (t.now_ms - frame_stamp > CHASE_MS) begin
					frame_stamp = t.now_ms;
					chase_pos   = chase_pos + 8'd1;
					for (i = 0; i < PIXEL_COUNT; i++)
						push_pixel(i, hue_to_rgb(8'((i * 256) / PIXEL_COUNT + chase_pos)));
				end
			end
			MODE_RED:   push_solid('{8'd255, 8'd0, 8'd0});
			MODE_GREEN: push_solid('{8'd0, 8'd255, 8'd0});
			MODE_BLUE:  push_solid('{8'd0, 8'd0, 8'd255});
			MODE_WHITE: push_solid('{8'd255, 8'd255, 8'd255});
			MODE_SCAN: begin
				// shares the frame timestamp with the chase
				if (t.now_ms - frame_stamp > SCAN_MS) begin
					frame_stamp = t.now_ms;
					scan_pos    = 6'((int'(scan_pos) + 1) % PIXEL_COUNT);
					nxt         = (int'(scan_pos) + 1) % PIXEL_COUNT;
					prv         = (int'(scan_pos) + PIXEL_COUNT - 1) % PIXEL_COUNT;
					for (i = 0; i < PIXEL_COUNT; i++) begin
						if (i == int'(scan_pos))
							push_pixel(i, '{8'd0, 8'd0, SCAN_PEAK});
						else if (i == nxt || i == prv)
							push_pixel(i, '{8'd0, 8'd0, SCAN_SIDE});
						else
							push_pixel(i, '{8'd0, 8'd0, SCAN_BASE});
					end
				end
			end
			MODE_TEST: begin
				// a zero step time means not started, even after a wrap
				if (test_stamp == 32'd0) begin
					test_stamp = t.now_ms;
					test_idx   = 3'd0;
				end
				// at most one step per tick
				if (t.now_ms - test_stamp >= TEST_STEP_MS) begin
					test_stamp = test_stamp + TEST_STEP_MS;
					test_idx   = test_idx + 3'd1;
				end
				if (test_idx == TEST_DONE) begin
					shown_mode = MODE_IDLE;
					test_stamp = 32'd0;
					push_solid('{8'd0, 8'd0, 8'd0});
				end else begin
					push_solid(test_card(test_idx));
				end
			end
			MODE_BREATH: begin
				if (breath_origin == 32'd0) begin
					breath_origin = t.now_ms;
					breath_stamp  = t.now_ms;
				end
				since = t.now_ms - breath_origin;
				if (since >= BREATH_RUN_MS) begin
					shown_mode    = MODE_IDLE;
					breath_origin = 32'd0;
					push_solid('{8'd0, 8'd0, 8'd0});
				end else if (t.now_ms - breath_stamp >= BREATH_TICK_MS) begin
					breath_stamp = t.now_ms;
					// triangle: up over 128 phases, down over the next 128
					phase = int'(since / BREATH_TICK_MS) % 256;
					level = (phase < 128) ? phase * 2 : 255 - (phase - 128) * 2;
					push_solid('{8'd0, 8'(level), 8'd0});
				end
			end
			default: begin
				// idle and unused codes: no frame, no state change
			end
		endcase
	endfunction

	function automatic void flag_pixel(input string what, input pixel_t want, input pixel_t got);
		if (bad_pixels < REPORT_MAX) begin
			$write("%0t %s: expected px %0d rgb %02h %02h %02h last %0b, ",
				$realtime, what, want.pixel_index, want.color.red, want.color.green,
				want.color.blue, want.last_pixel);
			$display("got px %0d rgb %02h %02h %02h last %0b",
				got.pixel_index, got.color.red, got.color.green, got.color.blue,
				got.last_pixel);
		end
		bad_pixels++;
	endfunction

	// tick driver: predicts on each accepted transaction, then offers the next one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_bus.valid     <= 1'b0;
			tick_bus.now_ms    <= '0;
			tick_bus.load_mode <= 1'b0;
			tick_bus.mode      <= MODE_IDLE;
		end else begin
			if (tick_bus.valid && tick_bus.ready) begin
				bus_tick.now_ms    = tick_bus.now_ms;
				bus_tick.load_mode = tick_bus.load_mode;
				bus_tick.mode      = tick_bus.mode;
				render_tick(bus_tick);
				ticks_taken++;
			end
			// a held transaction stays put until accepted
			if (!tick_bus.valid || tick_bus.ready) begin
				if (ticks_pending.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
					next_tick = ticks_pending.pop_front();
					tick_bus.valid     <= 1'b1;
					tick_bus.now_ms    <= next_tick.now_ms;
					tick_bus.load_mode <= next_tick.load_mode;
					tick_bus.mode      <= next_tick.mode;
				end else begin
					tick_bus.valid <= 1'b0;
				end
			end
		end
	end

	// pixel monitor: checks each accepted transaction against the oldest owed pixel
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_bus.ready <= 1'b0;
		end else begin
			if (pixel_bus.valid && pixel_bus.ready) begin
				got_px.pixel_index = pixel_bus.pixel_index;
				got_px.color.red   = pixel_bus.red;
				got_px.color.green = pixel_bus.green;
				got_px.color.blue  = pixel_bus.blue;
				got_px.last_pixel  = pixel_bus.last_pixel;
				if (pixels_due.size() == 0) begin
					flag_pixel("unexpected pixel", '0, got_px);
				end else begin
					want_px = pixels_due.pop_front();
					if (got_px.pixel_index !== want_px.pixel_index ||
						got_px.color.red !== want_px.color.red ||
						got_px.color.green !== want_px.color.green ||
						got_px.color.blue !== want_px.color.blue ||
						got_px.last_pixel !== want_px.last_pixel)
						flag_pixel("pixel mismatch", want_px, got_px);
				end
			end
			pixel_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// enable register writer, only fed while the block is idle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_bus.valid      <= 1'b0;
			cfg_bus.led_enable <= 1'b0;
		end else if (cfg_bus.valid && cfg_bus.ready) begin
			strip_on = cfg_bus.led_enable;
			enable_writes_done++;
			cfg_bus.valid <= 1'b0;
		end else if (!cfg_bus.valid && enable_writes.size() != 0) begin
			cfg_bus.valid      <= 1'b1;
			cfg_bus.led_enable <= enable_writes.pop_front();
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles_run++;
		if (cycles_run >= CYCLE_LIMIT) begin
			$display("led_strip_animation_generator test failed");
			$finish;
		end
	end

	task automatic queue_tick(input logic [31:0] now, input logic load, input logic [3:0] m);
		tick_t t;
		t.now_ms    = now;
		t.load_mode = load;
		t.mode      = m;
		ticks_pending.push_back(t);
		ticks_queued++;
	endtask

	// drain every tick and owed pixel, then let ticks without a frame finish too
	task automatic wait_idle();
		while (ticks_taken != ticks_queued || pixels_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_enable(input logic on);
		int target;
		target = enable_writes_done + 1;
		enable_writes.push_back(on);
		while (enable_writes_done < target)
			@(posedge clk);
	endtask

	// mostly runs of one mode with time steps that suit it, some noise in between
	task automatic queue_random_ticks(input int quota);
		int made;
		int run_len;
		int k;
		logic [3:0]  run_mode;
		logic        load;
		logic [31:0] step;
		made = 0;
		while (made < quota) begin
			if ($urandom_range(9) == 0) begin
				// noise: any time, any code, unused ones too
				queue_tick($urandom(), 1'($urandom_range(1)), 4'($urandom_range(15)));
			end else begin
				run_mode = 4'($urandom_range(MODE_CHASE, MODE_BREATH));
				if (run_mode == MODE_TEST || run_mode == MODE_BREATH)
					run_len = $urandom_range(6, 14);
				else
					run_len = $urandom_range(2, 8);
				// jump the clock now and then so every time bit toggles and wraps occur
				if ($urandom_range(3) == 0)
					sim_ms = $urandom();
				for (k = 0; k < run_len; k++) begin
					case (run_mode)
						MODE_CHASE:  step = $urandom_range(40, 260);
						MODE_SCAN:   step = $urandom_range(60, 360);
						MODE_TEST:   step = $urandom_range(500, 1300);
						MODE_BREATH: step = $urandom_range(1, 1800);
						default:     step = $urandom_range(1, 5000);
					endcase
					sim_ms = sim_ms + step;
					load   = (k == 0) || ($urandom_range(15) == 0);
					// the mode field is ignored without a load, so let it wander
					queue_tick(sim_ms, load, load ? run_mode : 4'($urandom()));
					made++;
				end
			end
		end
	endtask

	initial begin
		arst_n             = 1'b0;
		tick_bus.valid     = 1'b0;
		tick_bus.now_ms    = '0;
		tick_bus.load_mode = 1'b0;
		tick_bus.mode      = MODE_IDLE;
		pixel_bus.ready    = 1'b0;
		cfg_bus.valid      = 1'b0;
		cfg_bus.led_enable = 1'b0;
		strip_on           = 1'b0;
		shown_mode         = MODE_IDLE;
		frame_stamp        = '0;
		chase_pos          = '0;
		scan_pos           = '0;
		test_stamp         = '0;
		test_idx           = '0;
		breath_origin      = '0;
		breath_stamp       = '0;
		enable_writes_done = 0;
		ticks_queued       = 0;
		ticks_taken        = 0;
		bad_pixels         = 0;
		cycles_run         = 0;
		sim_ms             = 32'd20000;
		send_gap_pct       = 33;
		recv_stall_pct     = 78;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// strip off from reset: loads land, nothing is drawn
		queue_tick(32'd10, 1'b1, MODE_RED);
		queue_tick(32'd200, 1'b0, MODE_IDLE);
		queue_tick(32'hFFFF_FFFF, 1'b1, MODE_CHASE);
		wait_idle();
		write_enable(1'b0);
		queue_tick(32'd300, 1'b1, MODE_TEST);
		queue_tick(32'd400, 1'b1, MODE_BREATH);
		wait_idle();
		write_enable(1'b1);

		// solid colors
		queue_tick(32'd1000, 1'b1, MODE_RED);
		queue_tick(32'd1001, 1'b1, MODE_GREEN);
		queue_tick(32'd1002, 1'b1, MODE_BLUE);
		queue_tick(32'd1003, 1'b1, MODE_WHITE);
		// chase fires only strictly past 100 ms
		queue_tick(32'd1000, 1'b1, MODE_CHASE);
		queue_tick(32'd1100, 1'b0, MODE_IDLE);
		queue_tick(32'd1101, 1'b0, MODE_IDLE);
		// scanner shares the chase timestamp
		queue_tick(32'd1200, 1'b1, MODE_SCAN);
		queue_tick(32'd1252, 1'b0, MODE_IDLE);
		// test run whose step time wraps to zero, then restarts
		queue_tick(32'hFFFF_FCE0, 1'b1, MODE_TEST);
		queue_tick(32'd0, 1'b0, MODE_IDLE);
		queue_tick(32'd100, 1'b0, MODE_IDLE);
		// leave the test early and come back to the same run
		queue_tick(32'd200, 1'b1, MODE_RED);
		queue_tick(32'd1000, 1'b1, MODE_TEST);
		// breathing started at time zero restarts on the next tick
		queue_tick(32'd0, 1'b1, MODE_BREATH);
		queue_tick(32'd5000, 1'b0, MODE_IDLE);
		queue_tick(32'd5019, 1'b0, MODE_IDLE);
		queue_tick(32'd5020, 1'b0, MODE_IDLE);
		queue_tick(32'd7560, 1'b0, MODE_IDLE);
		queue_tick(32'd14999, 1'b0, MODE_IDLE);
		queue_tick(32'd15000, 1'b0, MODE_IDLE);
		queue_tick(32'd15100, 1'b0, MODE_IDLE);
		// unused code and explicit idle draw nothing
		queue_tick(32'hFFFF_FFFF, 1'b1, 4'hF);
		queue_tick(32'd15300, 1'b1, MODE_IDLE);
		wait_idle();

		// slow sender, very slow strip
		queue_random_ticks(40);
		wait_idle();

		// strip off mid-run: timers freeze, loads still land
		write_enable(1'b0);
		queue_random_ticks(6);
		wait_idle();
		write_enable(1'b1);

		// swap the idling sides
		send_gap_pct   = 78;
		recv_stall_pct = 33;
		queue_random_ticks(40);
		wait_idle();

		// back to back
		send_gap_pct   = 0;
		recv_stall_pct = 0;
		queue_random_ticks(40);
		wait_idle();

		if (pixels_due.size() != 0) begin
			$display("%0d expected pixels never arrived", pixels_due.size());
			bad_pixels++;
		end
		if (bad_pixels == 0)
			$display("led_strip_animation_generator test passed");
		else
			$display("led_strip_animation_generator test failed");
		$finish;
	end

endmodule

/* led_strip_animation_generator.f */
+incdir+rtl
rtl/lsag_pkg.sv
rtl/lsag_tick_if.sv
rtl/lsag_pix_if.sv
rtl/lsag_cfg_if.sv
rtl/lsag_ctrl.sv
rtl/lsag_dp.sv
rtl/led_strip_animation_generator.sv
tb/led_strip_animation_generator_tb.sv
